FILE: rtl/tqws_pkg.sv
// ----------------------------------------------------------------------------
// tqws_pkg
// Shared types and codes for the two-queue weighted server.
// ----------------------------------------------------------------------------
package tqws_pkg;

	// Default number of entries in each tag queue.
	localparam int QueueDepthDefault = 16;

	// Field widths.
	localparam int TagW   = 32;
	localparam int OpW    = 2;
	localparam int StW    = 2;
	localparam int BurstW = 4;

	// Reset value of the burst limit register.
	localparam logic [BurstW-1:0] BurstReset = 4'd3;

	// Operation codes.
	localparam logic [OpW-1:0] OP_ENQ_NORMAL   = 2'd0;
	localparam logic [OpW-1:0] OP_ENQ_PRIORITY = 2'd1;
	localparam logic [OpW-1:0] OP_SERVE        = 2'd2;
	localparam logic [OpW-1:0] OP_NONE         = 2'd3;

	// Result status codes.
	localparam logic [StW-1:0] ST_SERVED   = 2'd0;
	localparam logic [StW-1:0] ST_WAIT     = 2'd1;
	localparam logic [StW-1:0] ST_ENQUEUED = 2'd2;
	localparam logic [StW-1:0] ST_DROPPED  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;
	} tqws_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_none;
	} tqws_stat_t;

endpackage

FILE: rtl/two_queue_weighted_server_unit.sv
// ----------------------------------------------------------------------------
// two_queue_weighted_server_unit
// Weighted round-robin server over a normal and a priority tag queue.
// ----------------------------------------------------------------------------
// An accepted item's result is shown from the next cycle on, when the queue
// memory's registered read has delivered the served tag; the input stays stalled
// until that result has been taken, so the block handles one item at a time. An
// operation code of three is taken and discarded with no result. Queue storage
// needs no clearing after reset. The burst limit may be written only while idle.
module two_queue_weighted_server_unit #(
	parameter int QUEUE_DEPTH = tqws_pkg::QueueDepthDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic [tqws_pkg::BurstW-1:0]  cfg_write_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tqws_pkg::OpW-1:0]     operation,
	input  logic [tqws_pkg::TagW-1:0]    item_tag,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tqws_pkg::StW-1:0]     status,
	output logic [tqws_pkg::TagW-1:0]    served_tag,
	output logic                         from_priority
);
	import tqws_pkg::*;

	tqws_cmd_t  cmd;
	tqws_stat_t stat;

	// Handshake controller.
	tqws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Queues and scheduling datapath.
	tqws_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.operation      (operation),
		.item_tag       (item_tag),
		.cmd            (cmd),
		.stat           (stat),
		.status         (status),
		.served_tag     (served_tag),
		.from_priority  (from_priority)
	);

	// An executed item always yields a result in the next cycle.
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid)
		else $error("executed item gave no result");

	// No new item is taken while a result waits.
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// Only served results carry a tag or a priority flag.
	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_SERVED) |-> (served_tag == '0 && !from_priority))
		else $error("tag or flag on a result that served nothing");

	// A meaningless operation is never executed.
	a_op_none: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !stat.op_none)
		else $error("operation three executed");

endmodule

FILE: rtl/tqws_ctrl.sv
// ----------------------------------------------------------------------------
// tqws_ctrl
// Handshake controller: takes one item, then holds the result until taken.
// ----------------------------------------------------------------------------
module tqws_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  tqws_pkg::tqws_stat_t stat,
	output tqws_pkg::tqws_cmd_t  cmd
);
	import tqws_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_HOLD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	// Handshake outputs follow the state directly.
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_HOLD);

	// An item with no meaning is taken and dropped without a result.
	assign cmd.exec = (state_q == S_IDLE) && in_valid && !stat.op_none;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.exec) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/tqws_datapath.sv
// ----------------------------------------------------------------------------
// tqws_datapath
// Two tag queues in memories, their pointers and counts, the burst counter
// and the result registers.
// ----------------------------------------------------------------------------
module tqws_datapath #(
	parameter int QUEUE_DEPTH = tqws_pkg::QueueDepthDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic [tqws_pkg::BurstW-1:0]  cfg_write_data,
	input  logic [tqws_pkg::OpW-1:0]     operation,
	input  logic [tqws_pkg::TagW-1:0]    item_tag,
	input  tqws_pkg::tqws_cmd_t          cmd,
	output tqws_pkg::tqws_stat_t         stat,
	output logic [tqws_pkg::StW-1:0]     status,
	output logic [tqws_pkg::TagW-1:0]    served_tag,
	output logic                         from_priority
);
	import tqws_pkg::*;

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

	logic [TagW-1:0] norm_mem [QUEUE_DEPTH];
	logic [TagW-1:0] pri_mem  [QUEUE_DEPTH];

	logic [PtrW-1:0]   norm_head_q, norm_tail_q, pri_head_q, pri_tail_q;
	logic [CntW-1:0]   norm_count_q, pri_count_q;
	logic [BurstW-1:0] burst_count_q, priority_burst_q;
	logic [TagW-1:0]   norm_rd_q, pri_rd_q;
	logic [StW-1:0]    status_q;
	logic              from_pri_q;

	logic is_enq, is_serve, enq_pri;
	logic norm_full, pri_full, norm_any, pri_any, below_limit;
	logic pick_norm, pick_pri;
	logic norm_push, pri_push;

	// Wrapping increment for a queue pointer.
	function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
		next_slot = (p == PtrLast) ? '0 : p + 1'b1;
	endfunction

	assign stat.op_none = (operation == OP_NONE);

	// Decode of the operation and of the service choice.
	always_comb begin
		is_enq      = (operation == OP_ENQ_NORMAL) || (operation == OP_ENQ_PRIORITY);
		is_serve    = (operation == OP_SERVE);
		enq_pri     = (operation == OP_ENQ_PRIORITY);
		norm_full   = (norm_count_q == CntFull);
		pri_full    = (pri_count_q == CntFull);
		norm_any    = (norm_count_q != '0);
		pri_any     = (pri_count_q != '0);
		below_limit = (burst_count_q < priority_burst_q);
		if (below_limit) begin
			pick_pri  = pri_any;
			pick_norm = !pri_any && norm_any;
		end else begin
			pick_norm = norm_any;
			pick_pri  = !norm_any && pri_any;
		end
		norm_push = cmd.exec && is_enq && !enq_pri && !norm_full;
		pri_push  = cmd.exec && is_enq && enq_pri && !pri_full;
	end

	// Normal queue storage with registered read.
	always_ff @(posedge clk) begin
		if (norm_push) norm_mem[norm_tail_q] <= item_tag;
		if (cmd.exec && is_serve && pick_norm) norm_rd_q <= norm_mem[norm_head_q];
	end

	// Priority queue storage with registered read.
	always_ff @(posedge clk) begin
		if (pri_push) pri_mem[pri_tail_q] <= item_tag;
		if (cmd.exec && is_serve && pick_pri) pri_rd_q <= pri_mem[pri_head_q];
	end

	// Pointers, counts, burst counter and the burst limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_head_q      <= '0;
			norm_tail_q      <= '0;
			norm_count_q     <= '0;
			pri_head_q       <= '0;
			pri_tail_q       <= '0;
			pri_count_q      <= '0;
			burst_count_q    <= '0;
			priority_burst_q <= BurstReset;
		end else begin
			if (cfg_write_en) priority_burst_q <= cfg_write_data;
			if (norm_push) begin
				norm_tail_q  <= next_slot(norm_tail_q);
				norm_count_q <= norm_count_q + 1'b1;
			end
			if (pri_push) begin
				pri_tail_q  <= next_slot(pri_tail_q);
				pri_count_q <= pri_count_q + 1'b1;
			end
			if (cmd.exec && is_serve) begin
				if (pick_norm) begin
					norm_head_q  <= next_slot(norm_head_q);
					norm_count_q <= norm_count_q - 1'b1;
				end
				if (pick_pri) begin
					pri_head_q  <= next_slot(pri_head_q);
					pri_count_q <= pri_count_q - 1'b1;
				end
				if (!below_limit) begin
					burst_count_q <= '0;
				end else if (pick_pri) begin
					burst_count_q <= burst_count_q + 1'b1;
				end
			end
		end
	end

	// Result registers, loaded when an item is executed.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_enq) begin
				status_q   <= (enq_pri ? pri_full : norm_full) ? ST_DROPPED : ST_ENQUEUED;
				from_pri_q <= 1'b0;
			end else begin
				status_q   <= (pick_norm || pick_pri) ? ST_SERVED : ST_WAIT;
				from_pri_q <= pick_pri;
			end
		end
	end

	// The served tag comes from the served queue's memory read register, and is zero when nothing was served.
	assign status        = status_q;
	assign from_priority = (status_q == ST_SERVED) && from_pri_q;
	assign served_tag    = (status_q != ST_SERVED) ? '0 : (from_pri_q ? pri_rd_q : norm_rd_q);

endmodule
